// ----- rtl/core/bitmap_page_allocator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Bitmap page allocator assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define BPA_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpa assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define BPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpa assertion failed");
`else
`define BPA_ASSERT_IMPLIES(label, ante, cons)
`define BPA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Sizes, codes, sequencer states and shared types of the allocator core.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // map geometry
    localparam int MAX_PAGES   = 65536;
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int WORD_BITS   = 64;
    localparam int BIT_AW      = $clog2(WORD_BITS);
    localparam int IDX_W       = BIT_AW + 1;
    localparam int MAP_WORDS   = MAX_PAGES / WORD_BITS;
    localparam int WORD_AW     = $clog2(MAP_WORDS);
    localparam int PAGE_AW     = $clog2(MAX_PAGES);
    localparam int CNT_W       = PAGE_AW + 1;

    // port widths
    localparam int CFG_W       = 17;
    localparam int ADDR_W      = 48;
    localparam int POS_W       = ADDR_W + 2;
    localparam int PFN_W       = POS_W - PAGE_SHIFT;
    localparam int TOTAL_RESET = 65536;

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_FREE      = 2'd1,
        OP_MARK_USED = 2'd2,
        OP_MARK_FREE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_OOM     = 2'd1,
        STAT_DFREE   = 2'd2,
        STAT_IGNORED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        WOP_FIND  = 2'd0,
        WOP_SET   = 2'd1,
        WOP_CLEAR = 2'd2
    } word_op_t;

    // bit window [lo, hi_x) of one map word and what to do with it
    typedef struct packed {
        word_op_t           op;
        logic [BIT_AW-1:0]  lo;
        logic [IDX_W-1:0]   hi_x;
    } word_ctl_t;

    typedef struct packed {
        logic               found;
        logic [BIT_AW-1:0]  idx;
        logic               any_used;
    } word_stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_MOD,
        ST_ALLOC_SCAN,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_RANGE_SETUP,
        ST_RANGE_CLIP,
        ST_RANGE_WR
    } state_t;

    // page count in use: register value saturated at the map size
    function automatic logic [CNT_W-1:0] active_pages(input logic [CFG_W-1:0] tp);
        logic [CNT_W-1:0] res;
        if ({{(32-CFG_W){1'b0}}, tp} > 32'(MAX_PAGES))
            res = CNT_W'(MAX_PAGES);
        else
            res = CNT_W'(tp);
        return res;
    endfunction

endpackage

// ----- rtl/core/bitmap_page_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator core
// Next-fit page frame allocator over a one-bit-per-page used map in RAM.
// ----------------------------------------------------------------------------
// Allocate: answers out of memory from idle when the page count is zero, else
//   takes the hint remainder, then scans map words (up to words in use + 1).
// Free: check, word read, bit test and clear. Range mark: setup, clip, word writes.
// One command at a time; busy is high while a command runs and is low again when
// its result strobe comes, one beat each. The map word RAM read and update loop sets
// the rate: one word per cycle. Reset: a pass over every map word fills the map with ones (busy high meanwhile).
`include "bitmap_page_allocator_core_defines.svh"

module bitmap_page_allocator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [bpa_pkg::ADDR_W-1:0]    byte_address,
    input  logic [bpa_pkg::ADDR_W-1:0]    byte_length,
    output logic                          done,
    output logic [bpa_pkg::ADDR_W-1:0]    page_address,
    output logic [1:0]                    status,
    input  logic                          cfg_we,
    input  logic [bpa_pkg::CFG_W-1:0]     cfg_wdata
);
    import bpa_pkg::*;

    // control registers
    state_t             state_reg, state_next;
    logic [WORD_AW-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]   hint_reg, hint_next;
    logic [CFG_W-1:0]   total_pages_reg;
    logic               done_reg, done_next;
    logic               first_reg, first_next;
    logic               revisit_reg, revisit_next;

    // payload registers
    opcode_t            op_reg, op_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ADDR_W-1:0]  len_reg, len_next;
    logic [PFN_W-1:0]   pfn_first_reg, pfn_first_next;
    logic [PFN_W-1:0]   pfn_last_reg, pfn_last_next;
    logic [WORD_AW-1:0] cur_reg, cur_next;
    logic [WORD_AW-1:0] sw_reg, sw_next;
    logic [BIT_AW-1:0]  slo_reg, slo_next;
    logic [WORD_AW-1:0] lw_reg, lw_next;
    logic [BIT_AW-1:0]  lhi_reg, lhi_next;
    logic [ADDR_W-1:0]  page_address_reg, page_address_next;
    status_t            status_reg, status_next;

    // memory and shared units
    logic                 mem_we, mem_re;
    logic [WORD_AW-1:0]   mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
    logic                 mod_start, mod_done;
    logic [PAGE_AW-1:0]   mod_rem;
    word_ctl_t            wctl;
    logic [WORD_BITS-1:0] wnew;
    word_stat_t           wstat;

    // derived values
    logic                      accept;
    logic [CNT_W-1:0]          n_pages;
    logic [CNT_W-1:0]          n_m1;
    logic [WORD_AW-1:0]        last_word;
    logic [BIT_AW-1:0]         last_bit;
    logic [WORD_AW-1:0]        next_word;
    logic [IDX_W-1:0]          alloc_hi_base;
    logic [IDX_W-1:0]          alloc_hi;
    logic [ADDR_W-PAGE_SHIFT-1:0] free_pfn;
    logic                      free_ignore;
    logic [POS_W-1:0]          sum_end;
    logic [POS_W-1:0]          sum_end_up;
    logic [POS_W-1:0]          addr_up;
    logic [PFN_W-1:0]          n_pfn;
    logic [PFN_W-1:0]          last_clip;
    logic [PFN_W-1:0]          last_m1;
    logic                      range_empty;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign n_pages   = active_pages(total_pages_reg);
    assign n_m1      = n_pages - CNT_W'(1);
    assign last_word = n_m1[PAGE_AW-1:BIT_AW];
    assign last_bit  = n_m1[BIT_AW-1:0];
    assign next_word = (cur_reg == last_word) ? '0 : cur_reg + WORD_AW'(1);

    // allocation window: bounded by the page count, and below the start bit on revisit
    assign alloc_hi_base = (cur_reg == last_word) ? ({1'b0, last_bit} + IDX_W'(1))
                                                  : IDX_W'(WORD_BITS);
    assign alloc_hi = (revisit_reg && ({1'b0, slo_reg} < alloc_hi_base))
                      ? {1'b0, slo_reg} : alloc_hi_base;

    // free checks
    assign free_pfn    = addr_reg[ADDR_W-1:PAGE_SHIFT];
    assign free_ignore = (addr_reg == '0) ||
                         (free_pfn >= (ADDR_W-PAGE_SHIFT)'(n_pages));

    // range bounds
    assign sum_end    = {2'b00, addr_reg} + {2'b00, len_reg};
    assign sum_end_up = sum_end + POS_W'(PAGE_BYTES - 1);
    assign addr_up    = {2'b00, addr_reg} + POS_W'(PAGE_BYTES - 1);
    assign n_pfn      = PFN_W'(n_pages);
    assign last_clip  = (pfn_last_reg > n_pfn) ? n_pfn : pfn_last_reg;
    assign last_m1    = last_clip - PFN_W'(1);
    assign range_empty = (pfn_first_reg >= last_clip);

    bpa_map_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bpa_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (hint_reg),
        .divisor  (n_pages),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    bpa_word_unit u_word (
        .ctl      (wctl),
        .data     (mem_rdata),
        .new_data (wnew),
        .stat     (wstat)
    );

    // word unit control per state
    always_comb
    begin
        wctl.op   = WOP_FIND;
        wctl.lo   = '0;
        wctl.hi_x = '0;
        case (state_reg)
            ST_ALLOC_SCAN:
            begin
                wctl.op   = WOP_FIND;
                wctl.lo   = first_reg ? slo_reg : '0;
                wctl.hi_x = alloc_hi;
            end
            ST_FREE_CHK:
            begin
                wctl.op   = WOP_CLEAR;
                wctl.lo   = free_pfn[BIT_AW-1:0];
                wctl.hi_x = {1'b0, free_pfn[BIT_AW-1:0]} + IDX_W'(1);
            end
            ST_RANGE_WR:
            begin
                wctl.op   = (op_reg == OP_MARK_USED) ? WOP_SET : WOP_CLEAR;
                wctl.lo   = (cur_reg == sw_reg) ? slo_reg : '0;
                wctl.hi_x = (cur_reg == lw_reg) ? ({1'b0, lhi_reg} + IDX_W'(1))
                                                : IDX_W'(WORD_BITS);
            end
            default:
            begin
                wctl.op = WOP_FIND;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == WORD_AW'(MAP_WORDS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode_t'(opcode))
                        OP_ALLOC: state_next = (n_pages == '0) ? ST_IDLE : ST_ALLOC_MOD;
                        OP_FREE:  state_next = ST_FREE_RD;
                        default:  state_next = ST_RANGE_SETUP;
                    endcase
                end
            end
            ST_ALLOC_MOD:
            begin
                if (mod_done)
                    state_next = ST_ALLOC_SCAN;
            end
            ST_ALLOC_SCAN:
            begin
                if (wstat.found || revisit_reg)
                    state_next = ST_IDLE;
            end
            ST_FREE_RD:
            begin
                state_next = free_ignore ? ST_IDLE : ST_FREE_CHK;
            end
            ST_FREE_CHK:    state_next = ST_IDLE;
            ST_RANGE_SETUP: state_next = ST_RANGE_CLIP;
            ST_RANGE_CLIP:
            begin
                state_next = range_empty ? ST_IDLE : ST_RANGE_WR;
            end
            ST_RANGE_WR:
            begin
                if (cur_reg == lw_reg)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs, memory access and datapath updates
    always_comb
    begin
        clr_next          = clr_reg;
        hint_next         = hint_reg;
        done_next         = 1'b0;
        first_next        = first_reg;
        revisit_next      = revisit_reg;
        op_next           = op_reg;
        addr_next         = addr_reg;
        len_next          = len_reg;
        pfn_first_next    = pfn_first_reg;
        pfn_last_next     = pfn_last_reg;
        cur_next          = cur_reg;
        sw_next           = sw_reg;
        slo_next          = slo_reg;
        lw_next           = lw_reg;
        lhi_next          = lhi_reg;
        page_address_next = page_address_reg;
        status_next       = status_reg;
        mem_we            = 1'b0;
        mem_waddr         = cur_reg;
        mem_wdata         = wnew;
        mem_re            = 1'b0;
        mem_raddr         = cur_reg;
        mod_start         = 1'b0;
        case (state_reg)
            // fill the map with ones after reset
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {WORD_BITS{1'b1}};
                clr_next  = clr_reg + WORD_AW'(1);
            end
            // take a command beat
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = opcode_t'(opcode);
                    addr_next = byte_address;
                    len_next  = byte_length;
                    if (opcode_t'(opcode) == OP_ALLOC)
                    begin
                        if (n_pages == '0)
                        begin
                            done_next         = 1'b1;
                            page_address_next = '0;
                            status_next       = STAT_OOM;
                        end
                        else
                        begin
                            mod_start = 1'b1;
                        end
                    end
                end
            end
            // start word is known: fetch it
            ST_ALLOC_MOD:
            begin
                if (mod_done)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = mod_rem[PAGE_AW-1:BIT_AW];
                    cur_next     = mod_rem[PAGE_AW-1:BIT_AW];
                    sw_next      = mod_rem[PAGE_AW-1:BIT_AW];
                    slo_next     = mod_rem[BIT_AW-1:0];
                    first_next   = 1'b1;
                    revisit_next = 1'b0;
                end
            end
            // one word per cycle until a free bit turns up or the start word comes round again
            ST_ALLOC_SCAN:
            begin
                if (wstat.found)
                begin
                    mem_we            = 1'b1;
                    hint_next         = CNT_W'({cur_reg, wstat.idx}) + CNT_W'(1);
                    done_next         = 1'b1;
                    page_address_next = {{(ADDR_W-PAGE_AW-PAGE_SHIFT){1'b0}},
                                         cur_reg, wstat.idx, {PAGE_SHIFT{1'b0}}};
                    status_next       = STAT_DONE;
                end
                else if (revisit_reg)
                begin
                    done_next         = 1'b1;
                    page_address_next = '0;
                    status_next       = STAT_OOM;
                end
                else
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = next_word;
                    cur_next     = next_word;
                    first_next   = 1'b0;
                    revisit_next = (next_word == sw_reg);
                end
            end
            ST_FREE_RD:
            begin
                if (free_ignore)
                begin
                    done_next         = 1'b1;
                    page_address_next = '0;
                    status_next       = STAT_IGNORED;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = free_pfn[PAGE_AW-1:BIT_AW];
                    cur_next  = free_pfn[PAGE_AW-1:BIT_AW];
                end
            end
            ST_FREE_CHK:
            begin
                done_next         = 1'b1;
                page_address_next = '0;
                if (!wstat.any_used)
                begin
                    status_next = STAT_DFREE;
                end
                else
                begin
                    mem_we      = 1'b1;
                    status_next = STAT_DONE;
                    if (CNT_W'(free_pfn[PAGE_AW-1:0]) < hint_reg)
                        hint_next = CNT_W'(free_pfn[PAGE_AW-1:0]);
                end
            end
            // used ranges round outward, free ranges inward
            ST_RANGE_SETUP:
            begin
                if (op_reg == OP_MARK_USED)
                begin
                    pfn_first_next = PFN_W'(addr_reg[ADDR_W-1:PAGE_SHIFT]);
                    pfn_last_next  = sum_end_up[POS_W-1:PAGE_SHIFT];
                end
                else
                begin
                    pfn_first_next = addr_up[POS_W-1:PAGE_SHIFT];
                    pfn_last_next  = sum_end[POS_W-1:PAGE_SHIFT];
                end
            end
            ST_RANGE_CLIP:
            begin
                if (range_empty)
                begin
                    done_next         = 1'b1;
                    page_address_next = '0;
                    status_next       = STAT_DONE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = pfn_first_reg[PAGE_AW-1:BIT_AW];
                    cur_next  = pfn_first_reg[PAGE_AW-1:BIT_AW];
                    sw_next   = pfn_first_reg[PAGE_AW-1:BIT_AW];
                    slo_next  = pfn_first_reg[BIT_AW-1:0];
                    lw_next   = last_m1[PAGE_AW-1:BIT_AW];
                    lhi_next  = last_m1[BIT_AW-1:0];
                end
            end
            // write this word while the next one is read
            ST_RANGE_WR:
            begin
                mem_we = 1'b1;
                if (cur_reg == lw_reg)
                begin
                    done_next         = 1'b1;
                    page_address_next = '0;
                    status_next       = STAT_DONE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cur_reg + WORD_AW'(1);
                    cur_next  = cur_reg + WORD_AW'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            hint_reg        <= '0;
            total_pages_reg <= CFG_W'(TOTAL_RESET);
            done_reg        <= 1'b0;
            first_reg       <= 1'b0;
            revisit_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            hint_reg    <= hint_next;
            done_reg    <= done_next;
            first_reg   <= first_next;
            revisit_reg <= revisit_next;
            if (cfg_we)
                total_pages_reg <= cfg_wdata;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        addr_reg         <= addr_next;
        len_reg          <= len_next;
        pfn_first_reg    <= pfn_first_next;
        pfn_last_reg     <= pfn_last_next;
        cur_reg          <= cur_next;
        sw_reg           <= sw_next;
        slo_reg          <= slo_next;
        lw_reg           <= lw_next;
        lhi_reg          <= lhi_next;
        page_address_reg <= page_address_next;
        status_reg       <= status_next;
    end

    assign done         = done_reg;
    assign page_address = page_address_reg;
    assign status       = status_reg;

    // checks
    `BPA_ASSERT_IMPLIES(a_done_when_idle, done, !busy)
    `BPA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
    `BPA_ASSERT_IMPLIES(a_fail_no_addr, done && (status_reg != STAT_DONE), page_address == '0)
    `BPA_ASSERT_IMPLIES(a_scan_has_pages, state_reg == ST_ALLOC_SCAN, n_pages != '0)

endmodule

// ----- rtl/core/bpa_map_ram.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator used-map RAM
// One write port and one registered read port, one map word per entry.
// ----------------------------------------------------------------------------
module bpa_map_ram (
    input  logic                           clk,
    input  logic                           we,
    input  logic [bpa_pkg::WORD_AW-1:0]    waddr,
    input  logic [bpa_pkg::WORD_BITS-1:0]  wdata,
    input  logic                           re,
    input  logic [bpa_pkg::WORD_AW-1:0]    raddr,
    output logic [bpa_pkg::WORD_BITS-1:0]  rdata
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/bpa_mod_unit.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator remainder unit
// Restoring remainder of the search hint by the page count, one bit a cycle.
// ----------------------------------------------------------------------------
module bpa_mod_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bpa_pkg::CNT_W-1:0]     dividend,
    input  logic [bpa_pkg::CNT_W-1:0]     divisor,
    output logic                          done,
    output logic [bpa_pkg::PAGE_AW-1:0]   rem
);
    import bpa_pkg::*;

    localparam int STEP_W = $clog2(CNT_W + 1);

    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W:0]    trial;

    // shift in the next dividend bit and try one subtract
    assign trial = {rem_reg, quo_reg[CNT_W-1]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            cnt_next = STEP_W'(CNT_W);
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - STEP_W'(1);
            quo_next = {quo_reg[CNT_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[CNT_W-1:0];
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[PAGE_AW-1:0];

endmodule

// ----- rtl/core/bpa_word_unit.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator word unit
// Shared mask, free-bit search and update logic for one map word.
// ----------------------------------------------------------------------------
module bpa_word_unit (
    input  bpa_pkg::word_ctl_t             ctl,
    input  logic [bpa_pkg::WORD_BITS-1:0]  data,
    output logic [bpa_pkg::WORD_BITS-1:0]  new_data,
    output bpa_pkg::word_stat_t            stat
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] pick;
    logic [BIT_AW-1:0]    idx;

    // window of bits [lo, hi_x)
    assign mask = ({WORD_BITS{1'b1}} << ctl.lo) & ~({WORD_BITS{1'b1}} << ctl.hi_x);
    assign cand = ~data & mask;

    // lowest free bit in the window
    always_comb
    begin
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
                idx = BIT_AW'(i);
        end
    end

    assign pick = {{(WORD_BITS-1){1'b0}}, 1'b1} << idx;

    always_comb
    begin
        case (ctl.op)
            WOP_FIND:  new_data = (|cand) ? (data | pick) : data;
            WOP_SET:   new_data = data | mask;
            WOP_CLEAR: new_data = data & ~mask;
            default:   new_data = data;
        endcase
    end

    assign stat.found    = |cand;
    assign stat.idx      = idx;
    assign stat.any_used = |(data & mask);

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator core testbench
// Sends allocate, free and range-mark commands over the start/busy port, with
// a few page-count settings in between, and checks every result beat against a table
// value or a predictor that keeps its own copy of the used map and search hint.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = '1;
    localparam int                DIR_ROWS      = 30;
    localparam int                RAND_PHASES   = 9;
    localparam int                PHASE_CMDS    = 78;
    localparam int                MAX_REPORTS   = 10;

    // one directed row: either a page-count write or a command
    typedef struct packed {
        bit                 cfg;
        logic [CFG_W-1:0]   cfg_val;
        opcode_t            op;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  len;
        bit                 typed;
        logic [ADDR_W-1:0]  exp_addr;
        status_t            exp_st;
    } plan_row_t;

    typedef struct {
        logic [ADDR_W-1:0]  addr;
        status_t            st;
    } alloc_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         opcode = 2'd0;
    logic [ADDR_W-1:0]  byte_address = '0;
    logic [ADDR_W-1:0]  byte_length = '0;
    logic               done;
    logic [ADDR_W-1:0]  page_address;
    logic [1:0]         status;
    logic               cfg_we = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;

    // predictor state
    bit                 frame_used [MAX_PAGES];
    logic [CFG_W-1:0]   page_count_reg;
    logic [CFG_W-1:0]   next_fit_hint;

    alloc_result_t      pending_results [$];
    plan_row_t          dir_rows [0:DIR_ROWS-1];

    int                 error_count = 0;
    int                 cmds_sent = 0;
    int                 settings_used = 0;
    int                 grants = 0;
    int                 oom_count = 0;
    int                 dfree_count = 0;
    int                 ignored_count = 0;
    int                 range_count = 0;

    bitmap_page_allocator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .byte_address (byte_address),
        .byte_length  (byte_length),
        .done         (done),
        .page_address (page_address),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] rand48();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [CFG_W-1:0] pages_in_use();
        return (page_count_reg > CFG_W'(MAX_PAGES)) ? CFG_W'(MAX_PAGES) : page_count_reg;
    endfunction

    // next-fit allocator: updates the map and hint, returns the result beat
    function automatic void allocator_step(input opcode_t op, input logic [ADDR_W-1:0] addr,
                                           input logic [ADDR_W-1:0] len,
                                           output logic [ADDR_W-1:0] res_addr,
                                           output status_t res_st);
        logic [CFG_W-1:0]   n;
        logic [CFG_W-1:0]   pg;
        logic [35:0]        pfn;
        longint unsigned    first;
        longint unsigned    last;
        longint unsigned    p;
        int                 i;
        n = pages_in_use();
        res_addr = '0;
        res_st = STAT_DONE;
        case (op)
            OP_ALLOC:
            begin
                res_st = STAT_OOM;
                if (n != 0)
                begin
                    pg = next_fit_hint % n;
                    for (i = 0; i < int'(n); i++)
                    begin
                        if (!frame_used[pg[PAGE_AW-1:0]])
                        begin
                            frame_used[pg[PAGE_AW-1:0]] = 1'b1;
                            next_fit_hint = pg + 1'b1;
                            res_addr = ADDR_W'({pg, 12'h000});
                            res_st = STAT_DONE;
                            break;
                        end
                        pg = pg + 1'b1;
                        if (pg >= n)
                            pg = '0;
                    end
                end
            end
            OP_FREE:
            begin
                pfn = addr[ADDR_W-1:PAGE_SHIFT];
                if (addr == 0 || pfn >= 36'(n))
                    res_st = STAT_IGNORED;
                else if (!frame_used[pfn[PAGE_AW-1:0]])
                    res_st = STAT_DFREE;
                else
                begin
                    frame_used[pfn[PAGE_AW-1:0]] = 1'b0;
                    if (CFG_W'(pfn) < next_fit_hint)
                        next_fit_hint = CFG_W'(pfn);
                end
            end
            default:
            begin
                // used rounds outward, free rounds inward
                if (op == OP_MARK_USED)
                begin
                    first = longint'(addr) / PAGE_BYTES;
                    last = (longint'(addr) + longint'(len) + PAGE_BYTES - 1) / PAGE_BYTES;
                end
                else
                begin
                    first = (longint'(addr) + PAGE_BYTES - 1) / PAGE_BYTES;
                    last = (longint'(addr) + longint'(len)) / PAGE_BYTES;
                end
                if (last > longint'(n))
                    last = longint'(n);
                for (p = first; p < last; p++)
                    frame_used[p[PAGE_AW-1:0]] = (op == OP_MARK_USED);
            end
        endcase
    endfunction

    function automatic void flag_error(input string what, input logic [ADDR_W-1:0] want,
                                       input logic [ADDR_W-1:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR %s: expected %h, got %h at %0t", what, want, got, $realtime);
    endfunction

    // hold one command until accepted, then log what it should return
    task automatic send_cmd(input opcode_t op, input logic [ADDR_W-1:0] addr,
                            input logic [ADDR_W-1:0] len, input bit typed,
                            input logic [ADDR_W-1:0] exp_addr, input status_t exp_st);
        logic [ADDR_W-1:0]  pa;
        status_t            ps;
        alloc_result_t      beat;
        start <= 1'b1;
        opcode <= op;
        byte_address <= addr;
        byte_length <= len;
        do
            @(posedge clk);
        while (busy);
        allocator_step(op, addr, len, pa, ps);
        if (typed)
        begin
            beat.addr = exp_addr;
            beat.st = exp_st;
        end
        else
        begin
            beat.addr = pa;
            beat.st = ps;
        end
        pending_results.push_back(beat);
        cmds_sent++;
        case (beat.st)
            STAT_OOM:     oom_count++;
            STAT_DFREE:   dfree_count++;
            STAT_IGNORED: ignored_count++;
            default:
            begin
                if (op == OP_ALLOC)
                    grants++;
                else if (op != OP_FREE)
                    range_count++;
            end
        endcase
    endtask

    // page-count write, only once the core has gone quiet
    task automatic set_page_count(input logic [CFG_W-1:0] val);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        page_count_reg = val;
        settings_used++;
    endtask

    // result beats, compared in order
    always @(posedge clk)
    begin : check_results
        alloc_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                flag_error("unexpected result beat", '0, page_address);
            else
            begin
                want = pending_results.pop_front();
                if (page_address !== want.addr)
                    flag_error("page_address", want.addr, page_address);
                if (status !== want.st)
                    flag_error("status", ADDR_W'(want.st), ADDR_W'(status));
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int                 phase;
        int                 j;
        int                 r;
        int                 k;
        int                 rand_index;
        int                 phase_totals [RAND_PHASES];
        bit                 quiet;
        logic [CFG_W-1:0]   n;
        logic [35:0]        pfn;
        opcode_t            op;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  len;

        foreach (frame_used[i])
            frame_used[i] = 1'b1;
        next_fit_hint = '0;
        page_count_reg = CFG_W'(TOTAL_RESET);

        dir_rows = '{
            // fresh map: every frame used
            '{1'b0, 17'd0, OP_ALLOC,     48'd0,            48'd0,   1'b1, 48'd0,    STAT_OOM},
            '{1'b0, 17'd0, OP_FREE,      48'd0,            48'd0,   1'b1, 48'd0,    STAT_IGNORED},
            '{1'b0, 17'd0, OP_FREE,      48'h1000_0000,    48'd0,   1'b1, 48'd0,    STAT_IGNORED},
            '{1'b0, 17'd0, OP_FREE,      ADDR_ALL_ONES,    48'd0,   1'b1, 48'd0,    STAT_IGNORED},
            '{1'b0, 17'd0, OP_MARK_FREE, 48'd0,            48'h10000, 1'b1, 48'd0,  STAT_DONE},
            // frame zero comes back at address zero with a good status
            '{1'b0, 17'd0, OP_ALLOC,     48'd0,            48'd0,   1'b1, 48'd0,    STAT_DONE},
            '{1'b0, 17'd0, OP_ALLOC,     48'd0,            48'd0,   1'b1, 48'h1000, STAT_DONE},
            '{1'b0, 17'd0, OP_FREE,      48'h1000,         48'd0,   1'b1, 48'd0,    STAT_DONE},
            '{1'b0, 17'd0, OP_FREE,      48'h1234,         48'd0,   1'b1, 48'd0,    STAT_DFREE},
            '{1'b0, 17'd0, OP_MARK_USED, 48'hFFF,          48'd2,   1'b0, 48'd0,    STAT_DONE},
            '{1'b0, 17'd0, OP_MARK_FREE, 48'h1001,         48'h2000, 1'b0, 48'd0,   STAT_DONE},
            '{1'b0, 17'd0, OP_MARK_USED, ADDR_ALL_ONES,    ADDR_ALL_ONES, 1'b1, 48'd0, STAT_DONE},
            '{1'b0, 17'd0, OP_MARK_FREE, 48'd0,            ADDR_ALL_ONES, 1'b1, 48'd0, STAT_DONE},
            '{1'b0, 17'd0, OP_ALLOC,     48'd0,            48'd0,   1'b0, 48'd0,    STAT_DONE},
            '{1'b0, 17'd0, OP_MARK_USED, 48'd0,            ADDR_ALL_ONES, 1'b1, 48'd0, STAT_DONE},
            // only the top frame free: the search runs up from the hint to reach it
            '{1'b0, 17'd0, OP_MARK_FREE, 48'hFFF_F000,     48'h1000, 1'b1, 48'd0,   STAT_DONE},
            '{1'b0, 17'd0, OP_ALLOC,     48'd0,            48'd0,   1'b0, 48'd0,    STAT_DONE},
            '{1'b0, 17'd0, OP_ALLOC,     48'd0,            48'd0,   1'b1, 48'd0,    STAT_OOM},
            '{1'b0, 17'd0, OP_FREE,      48'hFFF_F000,     48'd0,   1'b1, 48'd0,    STAT_DONE},
            // no frames managed
            '{1'b1, 17'd0, OP_ALLOC,     48'd0,            48'd0,   1'b0, 48'd0,    STAT_DONE},
            '{1'b0, 17'd0, OP_ALLOC,     48'd0,            48'd0,   1'b1, 48'd0,    STAT_OOM},
            '{1'b0, 17'd0, OP_FREE,      48'h1000,         48'd0,   1'b1, 48'd0,    STAT_IGNORED},
            '{1'b0, 17'd0, OP_MARK_FREE, 48'd0,            ADDR_ALL_ONES, 1'b1, 48'd0, STAT_DONE},
            // register above the map size saturates
            '{1'b1, 17'h1FFFF, OP_ALLOC, 48'd0,            48'd0,   1'b0, 48'd0,    STAT_DONE},
            '{1'b0, 17'd0, OP_ALLOC,     48'd0,            48'd0,   1'b0, 48'd0,    STAT_DONE},
            // single frame, hint past the count
            '{1'b1, 17'd1, OP_ALLOC,     48'd0,            48'd0,   1'b0, 48'd0,    STAT_DONE},
            '{1'b0, 17'd0, OP_ALLOC,     48'd0,            48'd0,   1'b0, 48'd0,    STAT_DONE},
            '{1'b0, 17'd0, OP_FREE,      48'hFFF,          48'd0,   1'b0, 48'd0,    STAT_DONE},
            '{1'b0, 17'd0, OP_ALLOC,     48'd0,            48'd0,   1'b0, 48'd0,    STAT_DONE},
            '{1'b1, 17'd65536, OP_ALLOC, 48'd0,            48'd0,   1'b0, 48'd0,    STAT_DONE}
        };

        phase_totals = '{64, 1000, 0, 4096, 65536, 200, 131071, 1, 0};
        phase_totals[RAND_PHASES-1] = $urandom_range(2, 3000);

        // reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (j = 0; j < DIR_ROWS; j++)
        begin
            if (dir_rows[j].cfg)
                set_page_count(dir_rows[j].cfg_val);
            else
                send_cmd(dir_rows[j].op, dir_rows[j].addr, dir_rows[j].len,
                         dir_rows[j].typed, dir_rows[j].exp_addr, dir_rows[j].exp_st);
        end

        // random phases, one page count each
        rand_index = 0;
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            set_page_count(CFG_W'(phase_totals[phase]));
            n = pages_in_use();
            for (j = 0; j < PHASE_CMDS; j++)
            begin
                r = $urandom_range(99);
                k = $urandom_range(99);
                addr = rand48();
                len = rand48();
                if (r < 40)
                    op = OP_ALLOC;
                else if (r < 70)
                begin
                    op = OP_FREE;
                    if (k < 80)
                    begin
                        pfn = 36'($urandom_range((n == 0) ? 0 : int'(n) - 1));
                        addr = {pfn, 12'($urandom)};
                    end
                    else if (k < 85)
                        addr = '0;
                    else if (k < 90)
                        addr = {36'(n), 12'h000};
                end
                else
                begin
                    op = (r < 85) ? OP_MARK_USED : OP_MARK_FREE;
                    pfn = 36'($urandom_range(int'(n)));
                    if (k < 90)
                    begin
                        addr = {pfn, 12'($urandom)};
                        len = ADDR_W'($urandom_range(0, 48 * PAGE_BYTES));
                    end
                    else if (k >= 95)
                        addr = {pfn, 12'($urandom)};
                end
                send_cmd(op, addr, len, 1'b0, '0, STAT_DONE);

                // sender gaps, none in a long stretch
                quiet = (rand_index >= 200 && rand_index < 350);
                rand_index++;
                if (!quiet && $urandom_range(99) < 13)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(posedge clk);
                end
            end
        end

        // drain
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);

        $display("Ran %0d commands over %0d page-count settings: %0d pages granted,",
                 cmds_sent, settings_used, grants);
        $display("%0d out of memory, %0d double frees, %0d ignored frees, %0d range marks.",
                 oom_count, dfree_count, ignored_count, range_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/bpa_map_ram.sv
rtl/core/bpa_mod_unit.sv
rtl/core/bpa_word_unit.sv
rtl/core/bitmap_page_allocator_core.sv
tb/sv/testbench.sv
